@@ hdl/mcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Masked column statistics package
// Field widths, register indexes, payload structs and the command/status
// structs that run between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int THR_W     = 31;
  localparam int SUM_W     = 48;
  localparam int SQSUM_W   = 64;
  localparam int TALLY_W   = 17;
  localparam int VAR_W     = 47;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_MAGNITUDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_CUTOFF    = 2'd2;

  localparam logic [THR_W-1:0] SMALL_THRESHOLD_RST = 31'd1;
  localparam logic [THR_W-1:0] UPPER_CUTOFF_RST    = 31'd65536;

  localparam logic signed [SAMPLE_W-1:0] I32_MAX = 32'sh7fffffff;
  localparam logic signed [SAMPLE_W-1:0] I32_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       keep;
    logic                       last;
  } mcs_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_value;
    logic [VAR_W-1:0]           variance_value;
    logic signed [SUM_W-1:0]    total_value;
    logic signed [SAMPLE_W-1:0] largest_value;
    logic signed [SAMPLE_W-1:0] smallest_value;
    logic [TALLY_W-1:0]         kept_count;
    logic [TALLY_W-1:0]         mean_count;
    logic                       empty_flag;
    logic                       saturated_flag;
  } mcs_out_t;

  // which quotient the shared divider works on
  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_M1,
    DIV_SQ
  } div_sel_t;

  typedef struct packed {
    logic     div_start;
    div_sel_t div_sel;
    logic     take_mean;
    logic     take_m1;
    logic     take_sq;
    logic     calc_diff;
    logic     sq_m1;
    logic     sq_diff;
    logic     calc_sum;
    logic     load_out;
  } mcs_cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic div_done;
    logic out_full;
  } mcs_status_t;

endpackage

`default_nettype wire

@@ hdl/mcs_divider.sv @@
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division of a 64-bit dividend by a 17-bit divisor, one quotient
// bit per clock. done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_divider
  import mcs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [SQSUM_W-1:0] dividend,
  input  wire logic [TALLY_W-1:0] divisor,
  output logic                    done,
  output logic [SQSUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(SQSUM_W);

  logic [TALLY_W-1:0] rem_r;
  logic [SQSUM_W-1:0] quo_r;
  logic [TALLY_W-1:0] divisor_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [TALLY_W:0]   shifted;
  logic [TALLY_W:0]   trial;
  logic               fits;

  assign shifted = {rem_r, quo_r[SQSUM_W-1]};
  assign trial   = shifted - {1'b0, divisor_r};
  assign fits    = shifted >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SQSUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= '0;
      quo_r     <= dividend;
      divisor_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial[TALLY_W-1:0] : shifted[TALLY_W-1:0];
      quo_r <= {quo_r[SQSUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ hdl/mcs_datapath.sv @@
// ----------------------------------------------------------------------------
// Masked column statistics datapath
// Config registers, the three-stage accumulation pipe, the shared squarer,
// the divider and the final mean/variance arithmetic with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_datapath
  import mcs_pkg::*;
#(
  parameter int MAX_ITEMS = 65536,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_data,
  input  wire logic                 in_accept,
  input  wire mcs_in_t              in_data,
  input  wire mcs_cmd_t             cmd,
  output mcs_status_t               status,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output mcs_out_t                  out_data
);

  localparam int TALLY_CAP  = (MAX_ITEMS < 131071) ? MAX_ITEMS : 131071;
  localparam int SNAP_LIMIT = ((1 << FRAC_BITS) - 1) / 1000;
  localparam int SUMX_W     = SUM_W + 1;
  localparam int SQX_W      = SQSUM_W + 1;

  localparam logic signed [SUM_W-1:0] S48_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] S48_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SQSUM_W-1:0] U47_MAX = {{(SQSUM_W-VAR_W){1'b0}}, {VAR_W{1'b1}}};

  // {saturated, clamped value} of a signed quotient given as sign and magnitude
  function automatic logic [SAMPLE_W:0] clamp_q(input logic neg,
                                                input logic [SUM_W-1:0] mag);
    logic [SUM_W-1:0] lim;
    lim = neg ? {{(SUM_W-SAMPLE_W){1'b0}}, I32_MIN} : {{(SUM_W-SAMPLE_W){1'b0}}, I32_MAX};
    if (mag > lim) begin
      clamp_q = {1'b1, neg ? I32_MIN : I32_MAX};
    end else begin
      clamp_q = {1'b0, neg ? SAMPLE_W'(-mag[SAMPLE_W-1:0]) : mag[SAMPLE_W-1:0]};
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_mag(input logic neg,
                                                    input logic [SUM_W-1:0] mag);
    logic [SUM_W-1:0] lim;
    lim = neg ? {{(SUM_W-SAMPLE_W){1'b0}}, I32_MIN} : {{(SUM_W-SAMPLE_W){1'b0}}, I32_MAX};
    clamp_mag = (mag > lim) ? lim[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUMX_W-1:0] x);
    if (x[SUMX_W-1] != x[SUM_W-1]) begin
      sat48 = x[SUMX_W-1] ? S48_MIN : S48_MAX;
    end else begin
      sat48 = x[SUM_W-1:0];
    end
  endfunction

  // ---------------- configuration ----------------
  logic             use_mag_r;
  logic [THR_W-1:0] small_thr_r;
  logic [THR_W-1:0] cutoff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_mag_r   <= 1'b0;
      small_thr_r <= SMALL_THRESHOLD_RST;
      cutoff_r    <= UPPER_CUTOFF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_USE_MAGNITUDE:   use_mag_r   <= cfg_data[0];
        CFG_SMALL_THRESHOLD: small_thr_r <= cfg_data;
        CFG_UPPER_CUTOFF:    cutoff_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: sample decode ----------------
  logic [SAMPLE_W-1:0]        in_mag;
  logic                       in_clip;
  logic signed [SAMPLE_W-1:0] in_v;

  assign in_mag  = in_data.sample[SAMPLE_W-1] ? SAMPLE_W'(-in_data.sample)
                                              : SAMPLE_W'(in_data.sample);
  assign in_clip = use_mag_r && (in_data.sample == I32_MIN);
  assign in_v    = !use_mag_r ? in_data.sample :
                   in_clip    ? I32_MAX : signed'(in_mag);

  logic                       s1_valid_r;
  logic signed [SAMPLE_W-1:0] s1_v_r;
  logic [SAMPLE_W-1:0]        s1_abs_r;
  logic                       s1_keep_r;
  logic                       s1_mean_r;
  logic                       s1_clip_r;
  logic                       s2_sq_r;

  always_ff @(posedge clk) begin
    s1_v_r    <= in_v;
    s1_abs_r  <= in_clip ? I32_MAX : in_mag;
    s1_keep_r <= in_data.keep && (in_mag > {1'b0, small_thr_r});
    s1_mean_r <= in_mag < {1'b0, cutoff_r};
    s1_clip_r <= in_clip;
  end

  // ---------------- accumulators ----------------
  logic signed [SUM_W-1:0]    mean_sum_r;
  logic [TALLY_W-1:0]         mean_tally_r;
  logic signed [SUM_W-1:0]    kept_sum_r;
  logic [SQSUM_W-1:0]         kept_sq_r;
  logic [TALLY_W-1:0]         kept_tally_r;
  logic signed [SAMPLE_W-1:0] largest_r;
  logic signed [SAMPLE_W-1:0] smallest_r;
  logic                       ovf_r;
  logic                       fin_sat_r;

  logic                       cap_hit;
  logic                       take;
  logic signed [SUMX_W-1:0]   kept_sum_wide;
  logic signed [SUMX_W-1:0]   mean_sum_wide;
  logic [SQX_W-1:0]           kept_sq_wide;
  logic                       stage2_ovf;
  logic                       stage3_ovf;

  assign cap_hit       = kept_tally_r >= TALLY_W'(TALLY_CAP);
  assign take          = s1_valid_r && s1_keep_r && !cap_hit;
  assign kept_sum_wide = SUMX_W'(kept_sum_r) + SUMX_W'(s1_v_r);
  assign mean_sum_wide = SUMX_W'(mean_sum_r) + SUMX_W'(s1_v_r);

  logic [SQSUM_W-1:0] prod_r;
  assign kept_sq_wide = {1'b0, kept_sq_r} + SQX_W'(prod_r >> FRAC_BITS);

  assign stage2_ovf = s1_valid_r &&
                      (s1_clip_r || (s1_keep_r && cap_hit) ||
                       (take && (kept_sum_wide[SUMX_W-1] != kept_sum_wide[SUM_W-1])) ||
                       (take && s1_mean_r &&
                        (mean_sum_wide[SUMX_W-1] != mean_sum_wide[SUM_W-1])));
  assign stage3_ovf = s2_sq_r && kept_sq_wide[SQX_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_sq_r    <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
      s2_sq_r    <= take;
    end
  end

  // ---------------- finalize: divider, squarer ----------------
  logic [SQSUM_W-1:0] div_dividend;
  logic [TALLY_W-1:0] div_divisor;
  logic               div_done;
  logic [SQSUM_W-1:0] div_quotient;
  logic [SUM_W-1:0]   mean_abs;
  logic [SUM_W-1:0]   kept_abs;

  assign mean_abs = mean_sum_r[SUM_W-1] ? SUM_W'(-mean_sum_r) : SUM_W'(mean_sum_r);
  assign kept_abs = kept_sum_r[SUM_W-1] ? SUM_W'(-kept_sum_r) : SUM_W'(kept_sum_r);

  always_comb begin
    case (cmd.div_sel)
      DIV_MEAN: begin
        div_dividend = SQSUM_W'(mean_abs);
        div_divisor  = mean_tally_r;
      end
      DIV_M1: begin
        div_dividend = SQSUM_W'(kept_abs);
        div_divisor  = kept_tally_r;
      end
      default: begin
        div_dividend = kept_sq_r;
        div_divisor  = kept_tally_r;
      end
    endcase
  end

  mcs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  logic [SUM_W-1:0]    q_mag;
  logic [SAMPLE_W:0]   q_mean_clamp;
  logic [SAMPLE_W:0]   q_m1_clamp;

  assign q_mag        = div_quotient[SUM_W-1:0];
  assign q_mean_clamp = clamp_q(mean_sum_r[SUM_W-1], q_mag);
  assign q_m1_clamp   = clamp_q(kept_sum_r[SUM_W-1], q_mag);

  logic signed [SAMPLE_W-1:0] mu_r;
  logic signed [SAMPLE_W-1:0] m1_r;
  logic [SAMPLE_W-1:0]        m1_abs_r;
  logic [SQSUM_W-1:0]         a_r;
  logic [SAMPLE_W-1:0]        ad_r;
  logic [SQSUM_W-1:0]         m1sq_r;
  logic [SQSUM_W-1:0]         t_r;

  logic signed [SAMPLE_W:0]   diff_w;
  logic [SAMPLE_W-1:0]        sq_op;
  logic [SQSUM_W-1:0]         sq_prod;
  logic [SQX_W-1:0]           t_wide;

  assign diff_w  = (SAMPLE_W+1)'(m1_r) - (SAMPLE_W+1)'(mu_r);
  // one squarer serves the sample pipe and both variance terms
  assign sq_op   = cmd.sq_m1   ? m1_abs_r :
                   cmd.sq_diff ? ad_r     : s1_abs_r;
  assign sq_prod = SQSUM_W'(sq_op) * SQSUM_W'(sq_op);
  assign t_wide  = {1'b0, a_r} + SQX_W'(prod_r >> FRAC_BITS);

  always_ff @(posedge clk) begin
    prod_r <= sq_prod;
    if (cmd.take_mean) begin
      if (mean_tally_r == '0 || q_mag <= SUM_W'(SNAP_LIMIT)) begin
        mu_r <= '0;
      end else begin
        mu_r <= q_mean_clamp[SAMPLE_W-1:0];
      end
    end
    if (cmd.take_m1) begin
      m1_r     <= q_m1_clamp[SAMPLE_W-1:0];
      m1_abs_r <= clamp_mag(kept_sum_r[SUM_W-1], q_mag);
    end
    if (cmd.take_sq) begin
      a_r <= div_quotient;
    end
    if (cmd.calc_diff) begin
      ad_r <= diff_w[SAMPLE_W] ? SAMPLE_W'(-diff_w) : diff_w[SAMPLE_W-1:0];
    end
    if (cmd.sq_diff) begin
      m1sq_r <= prod_r >> FRAC_BITS;
    end
    if (cmd.calc_sum) begin
      t_r <= t_wide[SQX_W-1] ? {SQSUM_W{1'b1}} : t_wide[SQSUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      mean_sum_r   <= '0;
      mean_tally_r <= '0;
      kept_sum_r   <= '0;
      kept_sq_r    <= '0;
      kept_tally_r <= '0;
      largest_r    <= '0;
      smallest_r   <= I32_MAX;
      ovf_r        <= 1'b0;
      fin_sat_r    <= 1'b0;
    end else begin
      if (take) begin
        kept_tally_r <= kept_tally_r + TALLY_W'(1);
        kept_sum_r   <= sat48(kept_sum_wide);
        if (s1_v_r > largest_r) begin
          largest_r <= s1_v_r;
        end
        if (s1_v_r < smallest_r) begin
          smallest_r <= s1_v_r;
        end
        if (s1_mean_r) begin
          mean_tally_r <= mean_tally_r + TALLY_W'(1);
          mean_sum_r   <= sat48(mean_sum_wide);
        end
      end
      if (s2_sq_r) begin
        kept_sq_r <= kept_sq_wide[SQX_W-1] ? {SQSUM_W{1'b1}} : kept_sq_wide[SQSUM_W-1:0];
      end
      ovf_r <= ovf_r || stage2_ovf || stage3_ovf;
      if ((cmd.take_mean && mean_tally_r != '0 && q_mean_clamp[SAMPLE_W]) ||
          (cmd.take_m1 && kept_tally_r != '0 && q_m1_clamp[SAMPLE_W])) begin
        fin_sat_r <= 1'b1;
      end
    end
  end

  // ---------------- variance and result register ----------------
  logic [SQSUM_W-1:0] var_full;
  logic               var_clip;
  logic               kept_none;
  logic [VAR_W-1:0]   var_val;

  assign kept_none = kept_tally_r == '0;
  assign var_full  = (t_r > m1sq_r) ? t_r - m1sq_r : '0;
  assign var_clip  = !kept_none && (var_full > U47_MAX);
  assign var_val   = kept_none ? '0 :
                     var_clip  ? U47_MAX[VAR_W-1:0] : var_full[VAR_W-1:0];

  logic     out_valid_r;
  mcs_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.mean_value     <= mu_r;
      out_data_r.variance_value <= var_val;
      out_data_r.total_value    <= kept_sum_r;
      out_data_r.largest_value  <= largest_r;
      out_data_r.smallest_value <= smallest_r;
      out_data_r.kept_count     <= kept_tally_r;
      out_data_r.mean_count     <= mean_tally_r;
      out_data_r.empty_flag     <= kept_none || (mean_tally_r == '0);
      out_data_r.saturated_flag <= ovf_r || fin_sat_r || var_clip;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data          = out_data_r;
  assign status.pipe_empty = !s1_valid_r && !s2_sq_r;
  assign status.div_done   = div_done;
  assign status.out_full   = out_valid_r;

endmodule

`default_nettype wire

@@ hdl/mcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Masked column statistics controller
// Lets samples stream in, and on the item marked last drains the pipe and
// steps the datapath through the three divisions and the variance terms.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_ctrl
  import mcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_accept,
  input  wire logic        in_last,
  input  wire mcs_status_t status,
  output mcs_cmd_t         cmd,
  output logic             in_stall
);

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_DIV_MEAN,
    ST_DIV_M1,
    ST_DIV_SQ,
    ST_DIFF,
    ST_SQ_M1,
    ST_SQ_DIFF,
    ST_SUM,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_MEAN;
    unique case (state_r)
      ST_ACCUM: begin
        if (in_accept && in_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.pipe_empty) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_MEAN;
          state_nxt     = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (status.div_done) begin
          cmd.take_mean = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_M1;
          state_nxt     = ST_DIV_M1;
        end
      end
      ST_DIV_M1: begin
        if (status.div_done) begin
          cmd.take_m1   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SQ;
          state_nxt     = ST_DIV_SQ;
        end
      end
      ST_DIV_SQ: begin
        if (status.div_done) begin
          cmd.take_sq = 1'b1;
          state_nxt   = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_nxt     = ST_SQ_M1;
      end
      ST_SQ_M1: begin
        cmd.sq_m1 = 1'b1;
        state_nxt = ST_SQ_DIFF;
      end
      ST_SQ_DIFF: begin
        cmd.sq_diff = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.calc_sum = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the previous result to leave the output register
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_ACCUM;
        end
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_ACCUM;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= state_nxt != ST_ACCUM;
    end
  end

  assign in_stall = in_stall_r;

endmodule

`default_nettype wire

@@ hdl/masked_column_statistics_unit.sv @@
// ----------------------------------------------------------------------------
// Masked column statistics unit
// Mean, variance, sum, largest and smallest of a masked column of fixed-point
// samples, one result per column.
// ----------------------------------------------------------------------------
// Samples stream in at one item per clock; each goes through a three-stage
// pipe (decode, accumulate, square-sum) with no stall. The item marked last
// closes the column: input stalls while the pipe drains and one shared
// bit-serial divider runs three 64-step divisions (mean, kept mean, mean of
// squares), then a few squarer and adder steps form the variance. The result
// is valid once these steps are done and any previous result has left the
// output register; the input is free again in the same cycle that the result
// becomes valid. The result sits in an output register, so the next column
// can start streaming while it waits to be taken. Config registers are taken
// on any cycle; cfg_ready is always high.
`default_nettype none

module masked_column_statistics_unit
  import mcs_pkg::*;
#(
  parameter int MAX_ITEMS = 65536,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mcs_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output mcs_out_t                  out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_data
);

  mcs_cmd_t    cmd;
  mcs_status_t status;
  logic        in_accept;

  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  mcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_last   (in_data.last),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  mcs_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ hdl/mcs_checker.sv @@
// ----------------------------------------------------------------------------
// Masked column statistics port checker
// Watches the top-level ports for result consistency and the column-close
// stall, and is bound to every instance of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_checker
  import mcs_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire mcs_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire mcs_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // closing a column always stops the input for the finalize steps
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("input not stalled after column close");

  a_kept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kept_count == '0 |->
      out_data.variance_value == '0 && out_data.empty_flag)
    else $error("empty column with nonzero variance or no empty flag");

  a_mean_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mean_count == '0 |->
      out_data.mean_value == '0 && out_data.empty_flag)
    else $error("no mean samples but nonzero mean or no empty flag");

  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mean_count <= out_data.kept_count)
    else $error("mean count exceeds kept count");

endmodule

bind masked_column_statistics_unit mcs_checker u_mcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Masked column statistics unit testbench
// Streams columns of Q16.16 samples through the unit and folds every accepted
// item into a cycle-free model of the column statistics. Each result is
// checked field by field against the oldest pending prediction. A directed
// set covers the corner cases, then random columns run under several register
// settings with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import mcs_pkg::*;

  localparam int FRAC           = 16;
  localparam int TALLY_CAP      = 65536;
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 250;
  localparam int RANDOM_PHASES  = 8;

  localparam longint S48_TOP = 64'sh7fff_ffff_ffff;
  localparam longint S48_BOT = -S48_TOP - 1;
  localparam longint S32_TOP = 64'sh7fff_ffff;
  localparam longint S32_BOT = -S32_TOP - 1;
  localparam logic [63:0] U47_TOP = 64'h7fff_ffff_ffff;

  typedef struct {
    mcs_in_t item;
    int      gap;
  } sample_slot_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  mcs_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  mcs_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_data = '0;

  masked_column_statistics_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  bit               mag_mode = 1'b0;
  logic [THR_W-1:0] thr_r = SMALL_THRESHOLD_RST;
  logic [THR_W-1:0] cut_r = UPPER_CUTOFF_RST;

  // running column state
  longint      mean_acc, kept_acc, hi_v, lo_v;
  logic [63:0] sq_acc;
  int unsigned mean_n, kept_n;
  bit          ovf, clip_seen;

  sample_slot_t pending_samples[$];
  mcs_out_t     column_results_due[$];

  int samples_queued = 0;
  int samples_taken = 0;
  int columns_checked = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int empty_cols = 0;
  int sat_cols = 0;
  int gap_left = 0;
  int cur_gap = 0;
  int out_wait = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;

  task automatic clear_column();
    mean_acc = 0;
    mean_n   = 0;
    kept_acc = 0;
    sq_acc   = '0;
    kept_n   = 0;
    hi_v     = 0;
    lo_v     = S32_TOP;
    ovf      = 1'b0;
  endtask

  function automatic longint sat48(input longint acc, input longint inc);
    longint r;
    r = acc + inc;
    if (r > S48_TOP) begin
      ovf = 1'b1;
      return S48_TOP;
    end
    if (r < S48_BOT) begin
      ovf = 1'b1;
      return S48_BOT;
    end
    return r;
  endfunction

  function automatic longint clamp32(input longint x);
    if (x > S32_TOP) begin
      clip_seen = 1'b1;
      return S32_TOP;
    end
    if (x < S32_BOT) begin
      clip_seen = 1'b1;
      return S32_BOT;
    end
    return x;
  endfunction

  // Folds one accepted item into the column; the item marked last closes it.
  task automatic fold_sample(input mcs_in_t it);
    longint      s, v, m, m1, d, mu;
    logic [63:0] mag, sq, am, a, m1sq, ad, d2, t, spread;
    logic [64:0] wide;
    mcs_out_t    r;
    s = {{32{it.sample[31]}}, it.sample};
    mag = (s < 0) ? -s : s;
    v = s;
    if (mag_mode) begin
      v = mag;
      if (v > S32_TOP) begin
        v = S32_TOP;
        ovf = 1'b1;
      end
    end
    if (it.keep && mag > thr_r) begin
      if (kept_n >= TALLY_CAP) begin
        ovf = 1'b1;
      end else begin
        sq = v * v;
        sq = sq >> FRAC;
        kept_n++;
        kept_acc = sat48(kept_acc, v);
        wide = {1'b0, sq_acc} + {1'b0, sq};
        if (wide[64]) begin
          sq_acc = 64'hffff_ffff_ffff_ffff;
          ovf = 1'b1;
        end else begin
          sq_acc = wide[63:0];
        end
        if (v > hi_v) hi_v = v;
        if (v < lo_v) lo_v = v;
        if (mag < cut_r) begin
          mean_n++;
          mean_acc = sat48(mean_acc, v);
        end
      end
    end
    if (it.last) begin
      clip_seen = ovf;
      mu = 0;
      spread = '0;
      if (mean_n != 0) begin
        m = mean_acc / longint'(mean_n);
        am = (m < 0) ? -m : m;
        m = clamp32(m);
        // means under 0.001 snap to zero
        if (am * 64'd1000 < (64'd1 << FRAC)) m = 0;
        mu = m;
      end
      if (kept_n != 0) begin
        a = sq_acc / kept_n;
        m1 = clamp32(kept_acc / longint'(kept_n));
        m1sq = m1 * m1;
        m1sq = m1sq >> FRAC;
        d = m1 - mu;
        ad = (d < 0) ? -d : d;
        d2 = (ad * ad) >> FRAC;
        wide = {1'b0, a} + {1'b0, d2};
        t = wide[64] ? 64'hffff_ffff_ffff_ffff : wide[63:0];
        spread = (t > m1sq) ? t - m1sq : 64'd0;
        if (spread > U47_TOP) begin
          spread = U47_TOP;
          clip_seen = 1'b1;
        end
      end
      r.mean_value     = mu[31:0];
      r.variance_value = spread[VAR_W-1:0];
      r.total_value    = kept_acc[SUM_W-1:0];
      r.largest_value  = hi_v[31:0];
      r.smallest_value = lo_v[31:0];
      r.kept_count     = kept_n[TALLY_W-1:0];
      r.mean_count     = mean_n[TALLY_W-1:0];
      r.empty_flag     = (mean_n == 0 || kept_n == 0);
      r.saturated_flag = clip_seen;
      column_results_due.insert(column_results_due.size(), r);
      clear_column();
    end
  endtask

  task automatic cmp_field(input string name, input logic [63:0] exp_v,
                           input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t  %s: expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  // input driver: gap is the idle time after an item is taken
  always @(posedge clk) begin
    sample_slot_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        fold_sample(in_data);
        samples_taken++;
        gap_left = cur_gap;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          nxt = pending_samples.pop_front();
          in_data <= nxt.item;
          cur_gap = nxt.gap;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    mcs_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (column_results_due.size() == 0) begin
          mismatches++;
          $display("%0t  unexpected result: expected none, got %0h", $time, out_data);
        end else begin
          want = column_results_due.pop_front();
          cmp_field("mean_value", want.mean_value, out_data.mean_value);
          cmp_field("variance_value", want.variance_value, out_data.variance_value);
          cmp_field("total_value", want.total_value, out_data.total_value);
          cmp_field("largest_value", want.largest_value, out_data.largest_value);
          cmp_field("smallest_value", want.smallest_value, out_data.smallest_value);
          cmp_field("kept_count", want.kept_count, out_data.kept_count);
          cmp_field("mean_count", want.mean_count, out_data.mean_count);
          cmp_field("empty_flag", want.empty_flag, out_data.empty_flag);
          cmp_field("saturated_flag", want.saturated_flag, out_data.saturated_flag);
          columns_checked++;
          if (want.empty_flag) empty_cols++;
          if (want.saturated_flag) sat_cols++;
        end
        out_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      // one long hold-off so the next columns back up into the input
      if (hold_armed && !hold_done && out_valid) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (out_wait != 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t  timeout: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("masked_column_statistics_unit: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_USE_MAGNITUDE:   mag_mode = val[0];
      CFG_SMALL_THRESHOLD: thr_r = val;
      CFG_UPPER_CUTOFF:    cut_r = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic settle();
    while (samples_taken != samples_queued || column_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_sample(input logic [31:0] s, input bit k, input bit l, input int gap);
    sample_slot_t slot;
    slot.item.sample = s;
    slot.item.keep   = k;
    slot.item.last   = l;
    slot.gap         = gap;
    pending_samples.insert(pending_samples.size(), slot);
    samples_queued++;
  endtask

  task automatic add_directed(input logic [31:0] s, input bit k, input bit l);
    add_sample(s, k, l, $urandom_range(0, 8));
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2: s = $urandom;
      3, 4, 5: s = $urandom_range(0, 32'h0003_ffff);
      6:       s = $urandom_range(0, 32'h00ff_ffff);
      7:       s = {1'b0, thr_r} + $urandom_range(0, 2) - 1;
      8:       s = {1'b0, cut_r} + $urandom_range(0, 2) - 1;
      default: begin
        case ($urandom_range(0, 4))
          0:       s = 32'h7fff_ffff;
          1:       s = 32'h8000_0000;
          2:       s = 32'h0000_0000;
          3:       s = 32'h0000_0001;
          default: s = 32'h8000_0001;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) != 0) s = -s;
    return s;
  endfunction

  function automatic logic [THR_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return THR_W'($urandom_range(0, 32'h0002_0000));
      2:       return 31'h7fff_ffff;
      default: return THR_W'($urandom);
    endcase
  endfunction

  task automatic add_column(input int len, input bit mask_all, input bit burst);
    for (int i = 0; i < len; i++)
      add_sample(pick_sample(), mask_all ? 1'b0 : ($urandom_range(0, 3) != 0),
                 i == len - 1, burst ? 0 : $urandom_range(0, 8));
  endtask

  initial begin
    int               added, len;
    bit               m;
    logic [THR_W-1:0] th, cu;
    clear_column();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes, ignored tiny values, cutoff edge, masked last
    add_directed(32'h7fff_ffff, 1'b1, 1'b0);
    add_directed(32'h8000_0000, 1'b1, 1'b0);
    add_directed(32'h0000_0000, 1'b1, 1'b0);
    add_directed(32'h0000_0001, 1'b1, 1'b0);
    add_directed(32'h0000_0002, 1'b1, 1'b0);
    add_directed(32'h0001_0000, 1'b1, 1'b0);
    add_directed(32'hffff_0001, 1'b1, 1'b0);
    add_directed(32'h0001_2345, 1'b0, 1'b0);
    add_directed(32'h0000_8000, 1'b0, 1'b1);
    // empty column
    add_directed(32'h0000_0005, 1'b0, 1'b1);
    // tiny mean snaps to zero
    add_directed(32'h0000_0003, 1'b1, 1'b0);
    add_directed(32'h0000_0004, 1'b1, 1'b1);
    // nothing below the cutoff: mean set empty, kept set not
    add_directed(32'h0002_0000, 1'b1, 1'b0);
    add_directed(32'hfffd_0000, 1'b1, 1'b1);
    // negatives only: largest stays at zero
    add_directed(32'hffff_ff9c, 1'b1, 1'b0);
    add_directed(32'hffff_ff38, 1'b1, 1'b1);
    settle();

    // magnitude mode with the most negative sample
    write_reg(CFG_USE_MAGNITUDE, 31'd1);
    write_reg(CFG_SMALL_THRESHOLD, 31'd0);
    write_reg(CFG_UPPER_CUTOFF, 31'h7fff_ffff);
    add_directed(32'h8000_0000, 1'b1, 1'b0);
    add_directed(32'h7fff_fffe, 1'b1, 1'b0);
    add_directed(32'hffff_fffd, 1'b1, 1'b0);
    add_directed(32'h0000_0000, 1'b1, 1'b1);
    settle();

    // mean and kept mean far apart: variance clamps
    write_reg(CFG_USE_MAGNITUDE, 31'd0);
    add_directed(32'h7fff_fffe, 1'b1, 1'b0);
    add_directed(32'h8000_0000, 1'b1, 1'b0);
    add_directed(32'h8000_0000, 1'b1, 1'b0);
    add_directed(32'h8000_0000, 1'b1, 1'b1);
    settle();

    hold_armed = 1'b1;
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0: begin
          m = 1'b0; th = '0; cu = 31'h7fff_ffff;
        end
        1: begin
          m = 1'b1; th = 31'h7fff_ffff; cu = '0;
        end
        2: begin
          m = 1'b1; th = SMALL_THRESHOLD_RST; cu = '0;
        end
        3: begin
          m = 1'b0; th = SMALL_THRESHOLD_RST; cu = UPPER_CUTOFF_RST;
        end
        default: begin
          m = ($urandom_range(0, 1) != 0); th = pick_level(); cu = pick_level();
        end
      endcase
      write_reg(CFG_USE_MAGNITUDE, {30'd0, m});
      write_reg(CFG_SMALL_THRESHOLD, th);
      write_reg(CFG_UPPER_CUTOFF, cu);
      added = 0;
      while (added < PHASE_ITEMS) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        add_column(len, $urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0);
        added += len;
      end
      settle();
    end

    $display("%0d items in %0d columns checked over %0d register writes",
             samples_taken, columns_checked, reg_writes);
    $display("%0d columns flagged empty, %0d saturated, long receiver hold-off %s",
             empty_cols, sat_cols, hold_done ? "applied" : "not applied");
    if (mismatches == 0 && column_results_due.size() == 0) begin
      $display("masked_column_statistics_unit: match");
    end else begin
      $display("masked_column_statistics_unit: mismatch");
    end
    $finish;
  end

endmodule
